// File: hdl/ppti_pkg.sv
// Shared types and constants for the planar pose time interpolator.
// Depends on nothing; every other file of the block imports it.
package ppti_pkg;

	localparam int POS_W   = 32;  // Q16.16 position
	localparam int ANG_W   = 16;  // binary angle, one turn = 2**ANG_W
	localparam int TIME_W  = 48;  // timestamp in microseconds
	localparam int ALPHA_F = 16;  // fraction bits of alpha
	localparam int ALPHA_I = 8;   // integer bits of alpha, sign included

	// Alpha magnitude width. The divider also yields this many quotient bits:
	// one integer bit fewer (sign kept apart), one fraction bit more (rounding).
	localparam int ALPHA_W = ALPHA_I + ALPHA_F;

	localparam int QUEUE_DEPTH = 4;

	// Clock edges from the edge that accepts an item to the edge that takes
	// its result: time stage, divider, rounding, queue in and out, four back stages.
	localparam int LATENCY = ALPHA_W + 9;

	typedef enum logic [1:0] {
		STATUS_OK      = 2'd0,
		STATUS_ZERO_DT = 2'd1,
		STATUS_SAT     = 2'd2
	} status_t;

	typedef struct packed {
		logic signed [POS_W-1:0]  front_x;
		logic signed [POS_W-1:0]  front_y;
		logic signed [ANG_W-1:0]  front_heading;
		logic signed [POS_W-1:0]  back_x;
		logic signed [POS_W-1:0]  back_y;
		logic signed [ANG_W-1:0]  back_heading;
		logic [TIME_W-1:0]        front_time;
		logic [TIME_W-1:0]        back_time;
		logic [TIME_W-1:0]        now_time;
	} req_t;

	typedef struct packed {
		logic signed [POS_W-1:0]  fused_x;
		logic signed [POS_W-1:0]  fused_y;
		logic signed [ANG_W-1:0]  fused_heading;
		status_t                  status;
	} rsp_t;

	typedef struct packed {
		logic signed [POS_W-1:0]  fx;
		logic signed [POS_W-1:0]  fy;
		logic [ANG_W-1:0]         fh;
		logic signed [POS_W-1:0]  bx;
		logic signed [POS_W-1:0]  by;
		logic [ANG_W-1:0]         bh;
	} pose_pair_t;

	// Item handed from the front end to the back end through the queue.
	typedef struct packed {
		pose_pair_t          poses;
		logic [ALPHA_W-1:0]  alpha;
		logic                alpha_neg;
		logic                zero_dt;
		logic                alpha_sat;
	} fb_item_t;

endpackage

// File: hdl/ppti_front.sv
// Front end: time differences, pipelined restoring divider, alpha rounding and saturation.
// Depends on ppti_pkg.
module ppti_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  ppti_pkg::req_t     request,
	output logic               out_valid,
	output ppti_pkg::fb_item_t out_item
);
	import ppti_pkg::*;

	typedef struct packed {
		logic [TIME_W-1:0]   rem;
		logic [TIME_W-1:0]   den;
		logic [ALPHA_W-1:0]  feed;
		logic [ALPHA_W-1:0]  quo;
		logic                aneg;
		logic                zero;
		logic                sat;
		pose_pair_t          poses;
	} div_stage_t;

	localparam logic [ALPHA_W-1:0] LIM    = {1'b1, {(ALPHA_W-1){1'b0}}};
	localparam logic [ALPHA_W-1:0] LIM_M1 = {1'b0, {(ALPHA_W-1){1'b1}}};

	// One quotient bit: shift in the next dividend bit, subtract if it fits.
	function automatic div_stage_t div_step(input div_stage_t cur);
		div_stage_t nxt;
		logic [TIME_W:0] trial;
		logic take;
		nxt   = cur;
		trial = {cur.rem, cur.feed[ALPHA_W-1]};
		take  = (trial >= {1'b0, cur.den});
		nxt.rem  = take ? TIME_W'(trial - {1'b0, cur.den}) : trial[TIME_W-1:0];
		nxt.feed = {cur.feed[ALPHA_W-2:0], 1'b0};
		nxt.quo  = {cur.quo[ALPHA_W-2:0], take};
		return nxt;
	endfunction

	logic               now_lt, den_lt;
	logic [TIME_W-1:0]  num_c, den_c;

	logic               valid_s1;
	logic [TIME_W-1:0]  num_s1, den_s1;
	logic               aneg_s1, zero_s1;
	pose_pair_t         poses_s1;

	div_stage_t         dv_s2 [ALPHA_W+1];
	logic [ALPHA_W:0]   dv_valid_s2;

	logic               valid_s3;
	fb_item_t           item_s3;

	logic [ALPHA_W:0]   rnd_sum;
	logic [ALPHA_W-1:0] rnd_mag;

	always_comb begin
		now_lt = request.now_time < request.front_time;
		den_lt = request.back_time < request.front_time;
		num_c  = now_lt ? request.front_time - request.now_time
		                : request.now_time - request.front_time;
		den_c  = den_lt ? request.front_time - request.back_time
		                : request.back_time - request.front_time;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			dv_valid_s2 <= '0;
			valid_s3    <= 1'b0;
		end else begin
			valid_s1    <= accept;
			dv_valid_s2 <= {dv_valid_s2[ALPHA_W-1:0], valid_s1};
			valid_s3    <= dv_valid_s2[ALPHA_W];
		end
	end

	always_ff @(posedge clk) begin
		num_s1   <= num_c;
		den_s1   <= den_c;
		zero_s1  <= (request.back_time == request.front_time);
		aneg_s1  <= (now_lt != den_lt) && (request.now_time != request.front_time);
		poses_s1 <= '{fx: request.front_x, fy: request.front_y,
		              fh: request.front_heading, bx: request.back_x,
		              by: request.back_y, bh: request.back_heading};
	end

	// Quotient of num * 2**(ALPHA_F+1) / den fits ALPHA_W bits unless saturated.
	always_ff @(posedge clk) begin
		dv_s2[0].rem   <= TIME_W'(num_s1 >> (ALPHA_I - 1));
		dv_s2[0].den   <= den_s1;
		dv_s2[0].feed  <= {num_s1[ALPHA_I-2:0], {(ALPHA_F+1){1'b0}}};
		dv_s2[0].quo   <= '0;
		dv_s2[0].aneg  <= aneg_s1;
		dv_s2[0].zero  <= zero_s1;
		dv_s2[0].sat   <= ({{(ALPHA_I-1){1'b0}}, num_s1} >=
		                   {den_s1, {(ALPHA_I-1){1'b0}}});
		dv_s2[0].poses <= poses_s1;
		for (int k = 0; k < ALPHA_W; k++) begin
			dv_s2[k+1] <= div_step(dv_s2[k]);
		end
	end

	assign rnd_sum = {1'b0, dv_s2[ALPHA_W].quo} + (ALPHA_W+1)'(1);
	assign rnd_mag = rnd_sum[ALPHA_W:1];

	always_ff @(posedge clk) begin
		item_s3.poses     <= dv_s2[ALPHA_W].poses;
		item_s3.alpha_neg <= dv_s2[ALPHA_W].aneg;
		item_s3.zero_dt   <= dv_s2[ALPHA_W].zero;
		if (dv_s2[ALPHA_W].sat) begin
			item_s3.alpha     <= dv_s2[ALPHA_W].aneg ? LIM : LIM_M1;
			item_s3.alpha_sat <= 1'b1;
		end else if (!dv_s2[ALPHA_W].aneg && rnd_mag == LIM) begin
			item_s3.alpha     <= LIM_M1;
			item_s3.alpha_sat <= 1'b1;
		end else begin
			item_s3.alpha     <= rnd_mag;
			item_s3.alpha_sat <= 1'b0;
		end
	end

	assign out_valid = valid_s3;
	assign out_item  = item_s3;

endmodule

// File: hdl/ppti_queue.sv
// Short item queue between front end and back end, registered read.
// Depends on ppti_pkg.
module ppti_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  ppti_pkg::fb_item_t in_item,
	output logic               out_valid,
	output ppti_pkg::fb_item_t out_item,
	output logic               full
);
	import ppti_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	fb_item_t           mem_q [QUEUE_DEPTH];
	fb_item_t           out_item_q;
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               out_valid_q;
	logic               pop;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign pop = (count_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q    <= '0;
			rd_ptr_q    <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_valid) wr_ptr_q <= ptr_next(wr_ptr_q);
			if (pop) rd_ptr_q <= ptr_next(rd_ptr_q);
			count_q     <= count_q + CNT_W'(in_valid) - CNT_W'(pop);
			out_valid_q <= pop;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) mem_q[wr_ptr_q] <= in_item;
		if (pop) out_item_q <= mem_q[rd_ptr_q];
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;
	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));

endmodule

// File: hdl/ppti_back.sv
// Back end: position lerp and heading slerp with rounding and saturation.
// Depends on ppti_pkg.
module ppti_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  ppti_pkg::fb_item_t in_item,
	output logic               done,
	output ppti_pkg::rsp_t     result
);
	import ppti_pkg::*;

	localparam int LO_W   = (POS_W + 1) / 2;
	localparam int HI_W   = POS_W + 1 - LO_W;
	localparam int PROD_W = POS_W + 1 + ALPHA_W;
	localparam int MAG_W  = PROD_W - ALPHA_F;
	localparam int SUM_W  = MAG_W + 2;
	localparam int HP_W   = ANG_W + ALPHA_W;

	localparam logic [PROD_W-1:0] HALF_P = PROD_W'(1) << (ALPHA_F - 1);
	localparam logic [HP_W:0]     HALF_H = (HP_W+1)'(1) << (ALPHA_F - 1);
	localparam logic [SUM_W-1:0]  POS_MAX_E = {{(SUM_W-POS_W+1){1'b0}}, {(POS_W-1){1'b1}}};
	localparam logic [SUM_W-1:0]  POS_MIN_E = {{(SUM_W-POS_W+1){1'b1}}, {(POS_W-1){1'b0}}};

	typedef struct packed {
		logic signed [POS_W-1:0] px;
		logic signed [POS_W-1:0] py;
		logic [ANG_W-1:0]        fh;
		logic                    xneg;
		logic                    yneg;
		logic                    hneg;
		logic                    zero;
		logic                    sat;
	} side_t;

	function automatic logic [POS_W-1:0] clamp_pos(input logic [SUM_W-1:0] v);
		if ($signed(v) > $signed(POS_MAX_E)) return POS_MAX_E[POS_W-1:0];
		if ($signed(v) < $signed(POS_MIN_E)) return POS_MIN_E[POS_W-1:0];
		return v[POS_W-1:0];
	endfunction

	function automatic logic [SUM_W-1:0] apply_mag(input logic [POS_W-1:0] p,
	                                               input logic [MAG_W-1:0] m,
	                                               input logic neg);
		logic [SUM_W-1:0] pe, me;
		pe = {{(SUM_W-POS_W){p[POS_W-1]}}, p};
		me = {2'b00, m};
		return neg ? pe - me : pe + me;
	endfunction

	// stage 1 combinational: differences and magnitudes
	logic [POS_W:0]      fx_e, fy_e, bx_e, by_e;
	logic                lt_x, lt_y, dh_neg;
	logic [ANG_W-1:0]    dh_c;

	logic                valid_s1, valid_s2, valid_s3;
	side_t               side_s1, side_s2, side_s3;
	logic [POS_W:0]      dmx_s1, dmy_s1;
	logic [ANG_W-1:0]    dmh_s1;
	logic [ALPHA_W-1:0]  alpha_s1;

	logic [LO_W+ALPHA_W-1:0] xlo_s2, ylo_s2;
	logic [HI_W+ALPHA_W-1:0] xhi_s2, yhi_s2;
	logic [HP_W-1:0]         hp_s2;

	logic [PROD_W-1:0]   px_sum, py_sum;
	logic [HP_W:0]       hp_sum;
	logic [MAG_W-1:0]    mx_s3, my_s3;
	logic [ANG_W-1:0]    rm_s3;

	rsp_t                res_c;
	rsp_t                result_q;
	logic                done_q;

	always_comb begin
		fx_e   = {in_item.poses.fx[POS_W-1], in_item.poses.fx};
		fy_e   = {in_item.poses.fy[POS_W-1], in_item.poses.fy};
		bx_e   = {in_item.poses.bx[POS_W-1], in_item.poses.bx};
		by_e   = {in_item.poses.by[POS_W-1], in_item.poses.by};
		lt_x   = $signed(in_item.poses.bx) < $signed(in_item.poses.fx);
		lt_y   = $signed(in_item.poses.by) < $signed(in_item.poses.fy);
		dh_c   = in_item.poses.bh - in_item.poses.fh;
		dh_neg = dh_c[ANG_W-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			done_q   <= valid_s3;
		end
	end

	// stage 1: magnitudes of the pose differences, product signs
	always_ff @(posedge clk) begin
		dmx_s1       <= lt_x ? fx_e - bx_e : bx_e - fx_e;
		dmy_s1       <= lt_y ? fy_e - by_e : by_e - fy_e;
		dmh_s1       <= dh_neg ? in_item.poses.fh - in_item.poses.bh : dh_c;
		alpha_s1     <= in_item.alpha;
		side_s1.px   <= in_item.poses.fx;
		side_s1.py   <= in_item.poses.fy;
		side_s1.fh   <= in_item.poses.fh;
		side_s1.xneg <= lt_x != in_item.alpha_neg;
		side_s1.yneg <= lt_y != in_item.alpha_neg;
		side_s1.hneg <= dh_neg != in_item.alpha_neg;
		side_s1.zero <= in_item.zero_dt;
		side_s1.sat  <= in_item.alpha_sat;
	end

	// stage 2: partial products, position magnitudes split in two halves
	always_ff @(posedge clk) begin
		xlo_s2  <= (LO_W+ALPHA_W)'(dmx_s1[LO_W-1:0]) * (LO_W+ALPHA_W)'(alpha_s1);
		xhi_s2  <= (HI_W+ALPHA_W)'(dmx_s1[POS_W:LO_W]) * (HI_W+ALPHA_W)'(alpha_s1);
		ylo_s2  <= (LO_W+ALPHA_W)'(dmy_s1[LO_W-1:0]) * (LO_W+ALPHA_W)'(alpha_s1);
		yhi_s2  <= (HI_W+ALPHA_W)'(dmy_s1[POS_W:LO_W]) * (HI_W+ALPHA_W)'(alpha_s1);
		hp_s2   <= HP_W'(dmh_s1) * HP_W'(alpha_s1);
		side_s2 <= side_s1;
	end

	// stage 3: combine halves, round half up, drop fraction bits
	always_comb begin
		px_sum = PROD_W'(xlo_s2) + (PROD_W'(xhi_s2) << LO_W) + HALF_P;
		py_sum = PROD_W'(ylo_s2) + (PROD_W'(yhi_s2) << LO_W) + HALF_P;
		hp_sum = (HP_W+1)'(hp_s2) + HALF_H;
	end

	always_ff @(posedge clk) begin
		mx_s3   <= px_sum[PROD_W-1:ALPHA_F];
		my_s3   <= py_sum[PROD_W-1:ALPHA_F];
		rm_s3   <= hp_sum[ALPHA_F +: ANG_W];
		side_s3 <= side_s2;
	end

	// stage 4: apply to the front pose, clamp positions, wrap heading
	always_comb begin
		if (side_s3.zero) begin
			res_c.fused_x       = side_s3.px;
			res_c.fused_y       = side_s3.py;
			res_c.fused_heading = side_s3.fh;
			res_c.status        = STATUS_ZERO_DT;
		end else begin
			res_c.fused_x       = clamp_pos(apply_mag(side_s3.px, mx_s3, side_s3.xneg));
			res_c.fused_y       = clamp_pos(apply_mag(side_s3.py, my_s3, side_s3.yneg));
			res_c.fused_heading = side_s3.hneg ? side_s3.fh - rm_s3 : side_s3.fh + rm_s3;
			res_c.status        = side_s3.sat ? STATUS_SAT : STATUS_OK;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= res_c;
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// File: hdl/planar_pose_time_interpolator_top.sv
// Planar pose time interpolator: one result per item. Throughput is one item per
// cycle while busy is low; the divider and the four back stages are fully
// pipelined, so the rate is set by nothing but the single input port and busy.
// arst_n clears every valid bit, the queue pointers and count; payload registers keep data.
// Results cannot be held off; busy rises only if the queue fills.
module planar_pose_time_interpolator_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  ppti_pkg::req_t request,
	output logic           done,
	output ppti_pkg::rsp_t result
);
	import ppti_pkg::*;

	logic     accept;
	logic     fq_valid, qb_valid, queue_full;
	fb_item_t fq_item, qb_item;

	// Take an item whenever the queue has room; the front end never stalls.
	assign accept = start && !busy;
	assign busy   = queue_full;

	// Front end: time differences, alpha by long division, round and saturate.
	ppti_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.request   (request),
		.out_valid (fq_valid),
		.out_item  (fq_item)
	);

	// Queue: decouple the divider pipeline from the multiply pipeline.
	ppti_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fq_valid),
		.in_item   (fq_item),
		.out_valid (qb_valid),
		.out_item  (qb_item),
		.full      (queue_full)
	);

	// Back end: scale the pose differences by alpha, add to the front pose.
	// The zero-interval case bypasses the arithmetic and passes the front pose.
	ppti_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (qb_valid),
		.in_item  (qb_item),
		.done     (done),
		.result   (result)
	);

endmodule

// File: hdl/ppti_checker.sv
// Port-level checks for the planar pose time interpolator, bound to the top level.
// Depends on ppti_pkg.
module ppti_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input ppti_pkg::req_t request,
	input logic           done,
	input ppti_pkg::rsp_t result
);
	import ppti_pkg::*;

	logic accept;
	assign accept = start && !busy;

	// Every accepted item yields a result after the fixed latency.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##LATENCY done)
		else $error("missing result after accepted item");

	// No result without an item accepted the latency earlier.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LATENCY))
		else $error("result without matching item");

	// Zero interval passes the front x and heading through with its status.
	a_zero_dt: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (request.back_time == request.front_time) |-> ##LATENCY
		(result.status == STATUS_ZERO_DT &&
		 result.fused_x == $past(request.front_x, LATENCY) &&
		 result.fused_heading == $past(request.front_heading, LATENCY)))
		else $error("zero interval result wrong");

	// Current time at the front stamp gives alpha zero: the front pose, status ok.
	a_alpha_zero: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (request.now_time == request.front_time) &&
		(request.back_time != request.front_time) |-> ##LATENCY
		(result.status == STATUS_OK &&
		 result.fused_x == $past(request.front_x, LATENCY) &&
		 result.fused_y == $past(request.front_y, LATENCY) &&
		 result.fused_heading == $past(request.front_heading, LATENCY)))
		else $error("alpha zero result wrong");

endmodule

bind planar_pose_time_interpolator_top ppti_checker u_checker (.*);

// File: tb/pose_result_checker.sv
`timescale 1ns / 100ps
// Result checker for the planar pose time interpolator: predicts each pose from
// the accepted request and compares it with the next strobed result. Uses ppti_pkg.
module pose_result_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           busy,
	input  ppti_pkg::req_t request,
	input  logic           done,
	input  ppti_pkg::rsp_t result,
	output int             mismatches,
	output int             pending,
	output int             compared,
	output int             sat_seen,
	output int             zero_seen
);
	import ppti_pkg::*;

	localparam logic [63:0] ALPHA_LIM = 64'd1 << (ALPHA_F + ALPHA_I - 1);
	localparam longint POS_HI = (longint'(1) << (POS_W - 1)) - 1;
	localparam longint POS_LO = -POS_HI - 1;

	rsp_t expected_poses[$];
	int   err_count = 0;
	int   cmp_count = 0;
	int   sat_count = 0;
	int   zero_count = 0;

	assign mismatches = err_count;
	assign compared   = cmp_count;
	assign sat_seen   = sat_count;
	assign zero_seen  = zero_count;

	// {saturated, magnitude} of the time weight, rounded half up
	function automatic logic [ALPHA_W:0] alpha_weight(input logic [TIME_W-1:0] num,
		input logic [TIME_W-1:0] den, input logic neg);
		logic [TIME_W-1:0]  quo;
		logic [TIME_W-1:0]  rem;
		logic [127:0]       frac;
		logic [63:0]        mag;
		logic [ALPHA_W-1:0] lim_pos;
		logic [ALPHA_W-1:0] lim_neg;
		lim_pos = ALPHA_W'(ALPHA_LIM - 64'd1);
		lim_neg = ALPHA_W'(ALPHA_LIM);
		quo = num / den;
		rem = num % den;
		if (quo >= TIME_W'(64'd1 << (ALPHA_I - 1)))
			return {1'b1, neg ? lim_neg : lim_pos};
		frac = (128'(rem) << (ALPHA_F + 1)) / 128'(den);
		mag = (64'(quo) << ALPHA_F) + ((frac[63:0] + 64'd1) >> 1);
		if (!neg && mag > ALPHA_LIM - 64'd1)
			return {1'b1, lim_pos};
		if (neg && mag > ALPHA_LIM)
			return {1'b1, lim_neg};
		return {1'b0, mag[ALPHA_W-1:0]};
	endfunction

	// p1 + alpha * (p2 - p1), ties away from zero, clamped to the position range
	function automatic logic signed [POS_W-1:0] lerp_coord(input longint p1,
		input longint p2, input logic [ALPHA_W-1:0] amag, input logic aneg);
		longint       diff;
		longint       rv;
		logic         flip;
		logic [63:0]  dmag;
		logic [127:0] prod;
		diff = p2 - p1;
		flip = (diff < 0) != aneg;
		dmag = (diff < 0) ? 64'(-diff) : 64'(diff);
		prod = 128'(dmag) * 128'(amag) + (128'd1 << (ALPHA_F - 1));
		if ((prod >> (64 + ALPHA_F)) != 0 || (prod >> ALPHA_F) > (128'd1 << (POS_W + 1))) begin
			rv = flip ? POS_LO : POS_HI;
			return rv[POS_W-1:0];
		end
		rv = flip ? p1 - longint'(prod[ALPHA_F +: 64]) : p1 + longint'(prod[ALPHA_F +: 64]);
		if (rv > POS_HI)
			rv = POS_HI;
		if (rv < POS_LO)
			rv = POS_LO;
		return rv[POS_W-1:0];
	endfunction

	function automatic rsp_t predict_pose(input req_t rq);
		rsp_t                    rs;
		logic                    now_early;
		logic                    span_back;
		logic                    aneg;
		logic [TIME_W-1:0]       num;
		logic [TIME_W-1:0]       den;
		logic [ALPHA_W:0]        aw;
		logic [ALPHA_W-1:0]      amag;
		logic signed [ANG_W-1:0] dh;
		logic [63:0]             dmag;
		logic [63:0]             rmag;
		logic [63:0]             delta;
		if (rq.back_time == rq.front_time) begin
			rs.fused_x       = rq.front_x;
			rs.fused_y       = rq.front_y;
			rs.fused_heading = rq.front_heading;
			rs.status        = STATUS_ZERO_DT;
			return rs;
		end
		now_early = rq.now_time < rq.front_time;
		num = now_early ? rq.front_time - rq.now_time : rq.now_time - rq.front_time;
		span_back = rq.back_time < rq.front_time;
		den = span_back ? rq.front_time - rq.back_time : rq.back_time - rq.front_time;
		aneg = (now_early != span_back) && (num != 0);
		aw = alpha_weight(num, den, aneg);
		amag = aw[ALPHA_W-1:0];
		rs.fused_x = lerp_coord($signed(rq.front_x), $signed(rq.back_x), amag, aneg);
		rs.fused_y = lerp_coord($signed(rq.front_y), $signed(rq.back_y), amag, aneg);
		// shortest-path heading difference, then scale and wrap
		dh = rq.back_heading - rq.front_heading;
		dmag = (dh < 0) ? 64'(-longint'(dh)) : 64'(longint'(dh));
		rmag = (dmag * 64'(amag) + (64'd1 << (ALPHA_F - 1))) >> ALPHA_F;
		delta = ((dh < 0) != aneg) ? -rmag : rmag;
		rs.fused_heading = rq.front_heading + delta[ANG_W-1:0];
		rs.status = aw[ALPHA_W] ? STATUS_SAT : STATUS_OK;
		return rs;
	endfunction

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			if (done) begin
				if (expected_poses.size() == 0) begin
					$display("%0t: result with nothing expected: %p", $time, result);
					err_count++;
				end else begin
					want = expected_poses.pop_front();
					cmp_count++;
					if (want.status == STATUS_SAT)
						sat_count++;
					if (want.status == STATUS_ZERO_DT)
						zero_count++;
					if (result.fused_x !== want.fused_x) begin
						$display("%0t: fused_x expected %0d got %0d", $time, want.fused_x,
							result.fused_x);
						err_count++;
					end
					if (result.fused_y !== want.fused_y) begin
						$display("%0t: fused_y expected %0d got %0d", $time, want.fused_y,
							result.fused_y);
						err_count++;
					end
					if (result.fused_heading !== want.fused_heading) begin
						$display("%0t: fused_heading expected %0d got %0d", $time,
							want.fused_heading, result.fused_heading);
						err_count++;
					end
					if (result.status !== want.status) begin
						$display("%0t: status expected %0d got %0d", $time, want.status,
							result.status);
						err_count++;
					end
				end
			end
			if (start && !busy)
				expected_poses.insert(expected_poses.size(), predict_pose(request));
		end
		pending <= expected_poses.size();
	end

endmodule

// File: tb/planar_pose_time_interpolator_top_tb.sv
`timescale 1ns / 100ps
// Testbench top for the planar pose time interpolator: drives directed and random
// pose pairs, lets pose_result_checker predict and compare. Uses ppti_pkg.
module planar_pose_time_interpolator_top_tb;
	import ppti_pkg::*;

	// slowest run: ~1100 items, each with the longest idle gap plus the pipeline,
	// plus the drains; take that several times over
	localparam int TIMEOUT_CYCLES = 500000;
	localparam int RANDOM_ITEMS   = 1080;

	localparam logic signed [POS_W-1:0] POS_MAX_V = {1'b0, {(POS_W-1){1'b1}}};
	localparam logic signed [POS_W-1:0] POS_MIN_V = {1'b1, {(POS_W-1){1'b0}}};
	localparam logic signed [ANG_W-1:0] ANG_MAX_V = {1'b0, {(ANG_W-1){1'b1}}};
	localparam logic signed [ANG_W-1:0] ANG_MIN_V = {1'b1, {(ANG_W-1){1'b0}}};
	localparam logic [TIME_W-1:0]       TIME_MAX  = '1;
	localparam logic [TIME_W-1:0]       TICK17    = TIME_W'(64'd1 << 17);

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic done;
	req_t request = '0;
	rsp_t result;

	int mismatches;
	int pending;
	int compared;
	int sat_seen;
	int zero_seen;
	int cycles = 0;
	int sent_directed = 0;
	int sent_random = 0;

	always #5 clk = ~clk;

	planar_pose_time_interpolator_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.request (request),
		.done    (done),
		.result  (result)
	);

	pose_result_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.request    (request),
		.done       (done),
		.result     (result),
		.mismatches (mismatches),
		.pending    (pending),
		.compared   (compared),
		.sat_seen   (sat_seen),
		.zero_seen  (zero_seen)
	);

	// Watchdog: a hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= TIMEOUT_CYCLES) begin
			$display("FAIL planar_pose_time_interpolator_top");
			$finish;
		end
	end

	function automatic logic [TIME_W-1:0] rand48();
		return TIME_W'({$urandom, $urandom});
	endfunction

	// Mostly positions within a few hundred meters, sometimes the full range.
	function automatic logic signed [POS_W-1:0] rand_pos();
		if ($urandom_range(0, 3) == 0)
			return POS_W'($urandom);
		return POS_W'(int'($urandom_range(0, 33554432)) - 16777216);
	endfunction

	// A position hugging one end of the range, to push the result into clamping.
	function automatic logic signed [POS_W-1:0] edge_pos();
		if ($urandom_range(0, 1) == 0)
			return POS_MAX_V - POS_W'($urandom_range(0, 255));
		return POS_MIN_V + POS_W'($urandom_range(0, 255));
	endfunction

	function automatic req_t make_req(
		input logic signed [POS_W-1:0] fx, input logic signed [POS_W-1:0] fy,
		input logic signed [ANG_W-1:0] fh, input logic signed [POS_W-1:0] bx,
		input logic signed [POS_W-1:0] by, input logic signed [ANG_W-1:0] bh,
		input logic [TIME_W-1:0] t_front, input logic [TIME_W-1:0] t_back,
		input logic [TIME_W-1:0] t_now);
		req_t rq;
		rq.front_x       = fx;
		rq.front_y       = fy;
		rq.front_heading = fh;
		rq.back_x        = bx;
		rq.back_y        = by;
		rq.back_heading  = bh;
		rq.front_time    = t_front;
		rq.back_time     = t_back;
		rq.now_time      = t_now;
		return rq;
	endfunction

	// Mostly well-formed pose pairs with "now" in or just around the interval;
	// the rest covers full-range noise, zero intervals, clamped weights,
	// positions at the range ends and half-turn heading pairs.
	function automatic req_t random_request();
		req_t              rq;
		int                sel;
		logic [TIME_W-1:0] span;
		sel = $urandom_range(0, 99);
		span = TIME_W'($urandom_range(1, $urandom_range(1, 1000000)));
		rq.front_x       = rand_pos();
		rq.front_y       = rand_pos();
		rq.front_heading = ANG_W'($urandom);
		rq.back_x        = rand_pos();
		rq.back_y        = rand_pos();
		rq.back_heading  = ANG_W'($urandom);
		rq.front_time    = rand48();
		// ordinary timing; a quarter of the pairs come in reverse time order
		rq.back_time = ($urandom_range(0, 3) == 0) ? rq.front_time - span
			: rq.front_time + span;
		rq.now_time = rq.front_time - (span >> 2)
			+ TIME_W'($urandom_range(0, 32'(span + (span >> 1))));
		if (sel >= 55 && sel < 70) begin
			rq.back_time = rand48();
			rq.now_time  = rand48();
		end else if (sel >= 70 && sel < 78) begin
			rq.back_time = rq.front_time;
			if ($urandom_range(0, 1) == 0)
				rq.now_time = rand48();
		end else if (sel >= 78 && sel < 88) begin
			// weight near or past the clamp, on either side
			span = TIME_W'($urandom_range(1, 16));
			rq.back_time = rq.front_time + span;
			if ($urandom_range(0, 1) == 0)
				rq.now_time = rq.front_time + span * TIME_W'($urandom_range(120, 1000));
			else
				rq.now_time = rq.front_time - span * TIME_W'($urandom_range(120, 1000));
		end else if (sel >= 88 && sel < 94) begin
			rq.front_x = edge_pos();
			rq.front_y = edge_pos();
			rq.back_x  = edge_pos();
			rq.back_y  = edge_pos();
			rq.now_time = rq.front_time + span * TIME_W'($urandom_range(0, 20));
		end else if (sel >= 94) begin
			rq.back_heading = rq.front_heading ^ ANG_MIN_V;
			if ($urandom_range(0, 1) == 0)
				rq.back_heading = rq.back_heading + ANG_W'(int'($urandom_range(0, 2)) - 1);
		end
		return rq;
	endfunction

	// Mostly back to back, often a short pause, now and then a long one.
	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 60);
	endfunction

	// Offer one item after an optional pause; return at the edge that takes it.
	// Drop start only when pausing, so a back-to-back start is never lowered
	// and raised in the same step.
	task automatic send_item(input req_t rq, input int gap);
		if (gap > 0) begin
			start   <= 1'b0;
			request <= random_request();
			repeat (gap) @(posedge clk);
		end
		start   <= 1'b1;
		request <= rq;
		@(posedge clk iff !busy);
	endtask

	// Hold off the sender until every expected result has come back.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic send_directed(input req_t rq);
		send_item(rq, idle_gap());
		sent_directed++;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero interval: front pose passes through, also with every field at an end
		send_directed(make_req(rand_pos(), rand_pos(), 16'sd1234, rand_pos(), rand_pos(),
			-16'sd77, 48'd1000, 48'd1000, 48'd5000));
		send_directed(make_req(POS_MAX_V, POS_MIN_V, ANG_MIN_V, POS_MIN_V, POS_MAX_V,
			ANG_MAX_V, TIME_MAX, TIME_MAX, TIME_MAX));
		// weight 0, 1, one half, two and a half, minus one half
		send_directed(make_req(32'sd65536, -32'sd131072, 16'sd100, 32'sd655360,
			32'sd1000, 16'sd900, 48'd100, 48'd200, 48'd100));
		send_directed(make_req(32'sd65536, -32'sd131072, 16'sd100, 32'sd655360,
			32'sd1000, 16'sd900, 48'd100, 48'd200, 48'd200));
		send_directed(make_req(32'sd65536, -32'sd131072, 16'sd1000, 32'sd655360,
			32'sd1000, 16'sd3000, 48'd100, 48'd200, 48'd150));
		send_directed(make_req(32'sd65536, -32'sd131072, 16'sd1000, 32'sd655360,
			32'sd1000, 16'sd3000, 48'd100, 48'd200, 48'd350));
		send_directed(make_req(32'sd65536, -32'sd131072, 16'sd1000, 32'sd655360,
			32'sd1000, 16'sd3000, 48'd100, 48'd200, 48'd50));
		// back pose older than the front one, now inside and outside that span
		send_directed(make_req(-32'sd5000, 32'sd7000, -16'sd500, 32'sd9000, -32'sd3000,
			16'sd700, 48'd200, 48'd100, 48'd150));
		send_directed(make_req(-32'sd5000, 32'sd7000, -16'sd500, 32'sd9000, -32'sd3000,
			16'sd700, 48'd200, 48'd100, 48'd250));
		// now equal to the front time with a reversed interval: weight exactly zero
		send_directed(make_req(-32'sd5000, 32'sd7000, -16'sd500, 32'sd9000, -32'sd3000,
			16'sd700, 48'd200, 48'd100, 48'd200));
		// weight clamped high and low
		send_directed(make_req(32'sd10, 32'sd20, 16'sd30, 32'sd40, 32'sd50, 16'sd60,
			48'd0, 48'd1, TIME_MAX));
		send_directed(make_req(32'sd10, 32'sd20, 16'sd30, 32'sd40, 32'sd50, 16'sd60,
			48'd1000, 48'd1001, 48'd0));
		// rounding carries the weight onto 128: clamps when positive, exact -128 when not
		send_directed(make_req(32'sd1, -32'sd1, 16'sd3, 32'sd2, -32'sd2, 16'sd5,
			48'd0, TICK17, 128 * TICK17 - 48'd1));
		send_directed(make_req(32'sd1, -32'sd1, 16'sd3, 32'sd2, -32'sd2, 16'sd5,
			48'h4000_0000, 48'h4000_0000 + TICK17, 48'h4000_0000 - (128 * TICK17 - 48'd1)));
		// position overflow while extrapolating, and a full-range swing at the clamp
		send_directed(make_req(POS_MAX_V, POS_MIN_V, 16'sd0, POS_MIN_V, POS_MAX_V, 16'sd0,
			48'd0, 48'd10, 48'd20));
		send_directed(make_req(POS_MIN_V, POS_MAX_V, 16'sd0, POS_MAX_V, POS_MIN_V, 16'sd0,
			48'd0, 48'd1, 48'd500));
		// headings exactly half a turn apart go the negative way
		send_directed(make_req(32'sd0, 32'sd0, 16'sd0, 32'sd0, 32'sd0, ANG_MIN_V,
			48'd0, 48'd2, 48'd1));
		send_directed(make_req(32'sd0, 32'sd0, 16'sd16384, 32'sd0, 32'sd0, -16'sd16384,
			48'd0, 48'd2, 48'd1));
		// short path across the wrap point
		send_directed(make_req(32'sd0, 32'sd0, 16'sd32000, 32'sd0, 32'sd0, -16'sd32000,
			48'd0, 48'd2, 48'd1));
		// every pose field at its top, then reversed time at its ends
		send_directed(make_req(POS_MAX_V, POS_MAX_V, ANG_MAX_V, POS_MAX_V, POS_MAX_V,
			ANG_MAX_V, 48'd0, TIME_MAX, TIME_MAX));
		send_directed(make_req(POS_MIN_V, POS_MIN_V, ANG_MIN_V, POS_MIN_V, POS_MIN_V,
			ANG_MIN_V, TIME_MAX, 48'd0, 48'd0));
		// half-unit ties round away from zero, and a weight of one third
		send_directed(make_req(32'sd0, 32'sd0, 16'sd0, 32'sd1, -32'sd1, 16'sd1,
			48'd0, 48'd2, 48'd1));
		send_directed(make_req(32'sd0, 32'sd0, 16'sd0, 32'sd1, -32'sd1, -16'sd1,
			48'd0, 48'd3, 48'd1));

		// let the pipeline run dry once before the random part
		drain();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			// one long stretch runs with no idling at all
			send_item(random_request(), (i >= 300 && i < 500) ? 0 : idle_gap());
			sent_random++;
			if (i == 600)
				drain();
		end

		// wait out the last results, then give stray strobes time to show
		drain();
		repeat (LATENCY + 8) @(posedge clk);

		$display("Covered %0d directed and %0d random pose pairs, %0d results compared",
			sent_directed, sent_random, compared);
		$display("Results with zero interval: %0d, with clamped weight: %0d",
			zero_seen, sat_seen);
		if (mismatches == 0 && pending == 0)
			$display("PASS planar_pose_time_interpolator_top");
		else
			$display("FAIL planar_pose_time_interpolator_top");
		$finish;
	end

endmodule

// File: filelist.f
hdl/ppti_pkg.sv
hdl/ppti_front.sv
hdl/ppti_queue.sv
hdl/ppti_back.sv
hdl/planar_pose_time_interpolator_top.sv
hdl/ppti_checker.sv
tb/pose_result_checker.sv
tb/planar_pose_time_interpolator_top_tb.sv
